FILE: hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants for the servo packet framer: register indexes, byte
// slot codes, CRC polynomial and field widths.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned IN_DATA_W = 40;   // 35 payload bits padded to bytes

  // Packet limits
  localparam int unsigned MAX_PARAMS = 1024;
  localparam int unsigned LEN_BIAS   = 1 + 2;  // instruction plus two CRC bytes

  // CRC-16, not reflected, zero init, no final xor
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_A = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_B = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_C = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RESERVED = 2'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] RST_HEADER_A = 8'hFF;
  localparam logic [BYTE_W-1:0] RST_HEADER_B = 8'hFF;
  localparam logic [BYTE_W-1:0] RST_HEADER_C = 8'hFD;
  localparam logic [BYTE_W-1:0] RST_RESERVED = 8'h00;

  // Output byte slots of one item, in emission order
  localparam int unsigned NUM_SLOTS = 11;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_HDR_A   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR_B   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_HDR_C   = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_RSVD    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_ID      = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO  = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI  = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_INSTR   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_PARAM   = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_CRC_LO  = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_CRC_HI  = 4'd10;

endpackage

FILE: hdl/spf_crc_byte.sv
// ----------------------------------------------------------------------------
// spf_crc_byte
// One-byte update of the CRC-16 (MSB first, polynomial from the package).
// ----------------------------------------------------------------------------
module spf_crc_byte (
  input  logic [spf_pkg::CRC_W-1:0]  crc_i,
  input  logic [spf_pkg::BYTE_W-1:0] data_i,
  output logic [spf_pkg::CRC_W-1:0]  crc_o
);

  // Eight shift/xor steps, byte enters at the top
  always_comb begin
    logic [spf_pkg::CRC_W-1:0] c;
    c = crc_i ^ {data_i, {(spf_pkg::CRC_W - spf_pkg::BYTE_W){1'b0}}};
    for (int k = 0; k < spf_pkg::BYTE_W; k++) begin
      if (c[spf_pkg::CRC_W-1]) begin
        c = {c[spf_pkg::CRC_W-2:0], 1'b0} ^ spf_pkg::CRC_POLY;
      end else begin
        c = {c[spf_pkg::CRC_W-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

FILE: hdl/servo_packet_framer_crc16_unit.sv
// ----------------------------------------------------------------------------
// servo_packet_framer_crc16_unit
// Frames servo-bus command packets as a byte stream with a trailing CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item; the first item of a packet supplies
//   id, instruction and parameter count, later ones only parameter bytes.
//   tuser flags whether the item holds a parameter byte, tlast ends the
//   packet. m_axis delivers one framed byte per cycle unless stalled; its
//   tlast marks the high CRC byte closing the packet.
//   A request is registered on acceptance; its bytes (up to eleven) leave
//   one per cycle from the output register unless m_axis stalls. An item
//   with bytes holds off the input until its last byte is loaded; one with
//   none is absorbed without holding it. A request is accepted in the cycle
//   its predecessor's last byte is loaded, so single-byte items flow at one
//   per cycle unstalled; the byte emitter and one-byte CRC step set the rate.
//   Reset restores the header registers to their defaults, clears the CRC
//   and returns the framer to awaiting a packet start. When m_axis stalls
//   the output register holds its byte and the input backs up.
//   Configuration writes are not gated; issue them only while idle, since
//   header bytes are read from the registers as they leave.
// ----------------------------------------------------------------------------
module servo_packet_framer_crc16_unit #(
  parameter int unsigned MaxParams = spf_pkg::MAX_PARAMS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [spf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [spf_pkg::BYTE_W-1:0]        cfg_wdata_i,
  // Item stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: packet_id[7:0], instruction[15:8], param_count[26:16],
  //        param_byte[34:27], zero pad[39:35]
  input  logic [spf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: has_param[0]
  input  logic                              s_axis_tuser,
  // tlast: end_of_params
  input  logic                              s_axis_tlast,
  // Byte stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: out_byte[7:0]
  output logic [spf_pkg::BYTE_W-1:0]        m_axis_tdata,
  // tlast: last_byte
  output logic                              m_axis_tlast
);

  localparam int unsigned SatW = 17;
  localparam logic [SatW-1:0] MaxParamsW = SatW'(MaxParams);

  // Configuration registers
  logic [spf_pkg::BYTE_W-1:0] hdr_a_q, hdr_b_q, hdr_c_q, rsvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_a_q <= spf_pkg::RST_HEADER_A;
      hdr_b_q <= spf_pkg::RST_HEADER_B;
      hdr_c_q <= spf_pkg::RST_HEADER_C;
      rsvd_q  <= spf_pkg::RST_RESERVED;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        spf_pkg::REG_HEADER_A: hdr_a_q <= cfg_wdata_i;
        spf_pkg::REG_HEADER_B: hdr_b_q <= cfg_wdata_i;
        spf_pkg::REG_HEADER_C: hdr_c_q <= cfg_wdata_i;
        spf_pkg::REG_RESERVED: rsvd_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Unpack the request
  logic [spf_pkg::BYTE_W-1:0]  in_id, in_instr, in_param;
  logic [spf_pkg::COUNT_W-1:0] in_count;

  assign in_id    = s_axis_tdata[7:0];
  assign in_instr = s_axis_tdata[15:8];
  assign in_count = s_axis_tdata[26:16];
  assign in_param = s_axis_tdata[34:27];

  // Length field: saturated count plus bias
  logic [SatW-1:0]           count_w, count_sat;
  logic [spf_pkg::LEN_W-1:0] len_d;

  assign count_w   = SatW'(in_count);
  assign count_sat = (count_w > MaxParamsW) ? MaxParamsW : count_w;
  assign len_d     = spf_pkg::LEN_W'(count_sat + SatW'(spf_pkg::LEN_BIAS));

  // Item register and pending-slot mask
  logic                          pkt_q;
  logic [spf_pkg::NUM_SLOTS-1:0] rem_q, rem_d, mask_in, low_bit;
  logic [spf_pkg::BYTE_W-1:0]    id_q, instr_q, param_q;
  logic [spf_pkg::LEN_W-1:0]     len_q;
  logic [spf_pkg::CRC_W-1:0]     crc_q, crc_d, crc_upd;
  logic                          busy, emit, item_done, accept;

  assign mask_in = {{2{s_axis_tlast}}, s_axis_tuser, {8{~pkt_q}}};

  assign busy      = |rem_q;
  assign emit      = busy && (!m_axis_tvalid || m_axis_tready);
  assign low_bit   = rem_q & (~rem_q + spf_pkg::NUM_SLOTS'(1));
  assign item_done = emit && ((rem_q & ~low_bit) == '0);

  assign s_axis_tready = !busy || item_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Current slot: lowest pending bit
  logic [spf_pkg::SLOT_W-1:0] slot;

  always_comb begin
    slot = '0;
    for (int i = spf_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        slot = spf_pkg::SLOT_W'(i);
      end
    end
  end

  // Byte for the current slot
  logic [spf_pkg::BYTE_W-1:0] byte_sel;

  always_comb begin
    case (slot)
      spf_pkg::SLOT_HDR_A:  byte_sel = hdr_a_q;
      spf_pkg::SLOT_HDR_B:  byte_sel = hdr_b_q;
      spf_pkg::SLOT_HDR_C:  byte_sel = hdr_c_q;
      spf_pkg::SLOT_RSVD:   byte_sel = rsvd_q;
      spf_pkg::SLOT_ID:     byte_sel = id_q;
      spf_pkg::SLOT_LEN_LO: byte_sel = len_q[7:0];
      spf_pkg::SLOT_LEN_HI: byte_sel = len_q[15:8];
      spf_pkg::SLOT_INSTR:  byte_sel = instr_q;
      spf_pkg::SLOT_PARAM:  byte_sel = param_q;
      spf_pkg::SLOT_CRC_LO: byte_sel = crc_q[7:0];
      spf_pkg::SLOT_CRC_HI: byte_sel = crc_q[15:8];
      default:              byte_sel = '0;
    endcase
  end

  // Running CRC step
  spf_crc_byte u_crc (
    .crc_i  (crc_q),
    .data_i (byte_sel),
    .crc_o  (crc_upd)
  );

  always_comb begin
    crc_d = crc_q;
    if (emit) begin
      if (slot == spf_pkg::SLOT_CRC_HI) begin
        crc_d = '0;
      end else if (slot != spf_pkg::SLOT_CRC_LO) begin
        crc_d = crc_upd;
      end
    end
  end

  // Pending mask: retire emitted slot, load on accept
  always_comb begin
    rem_d = rem_q;
    if (emit) begin
      rem_d = rem_q & ~low_bit;
    end
    if (accept) begin
      rem_d = mask_in;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pkt_q <= 1'b0;
      crc_q <= '0;
    end else begin
      rem_q <= rem_d;
      crc_q <= crc_d;
      if (accept) begin
        pkt_q <= ~s_axis_tlast;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q    <= in_id;
      instr_q <= in_instr;
      param_q <= in_param;
      len_q   <= len_d;
    end
  end

  // Output register
  logic                       out_valid_q;
  logic [spf_pkg::BYTE_W-1:0] out_data_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= byte_sel;
      out_last_q <= (slot == spf_pkg::SLOT_CRC_HI);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
